>>> hdl/bipc_pkg.sv
// Package for the block I/O pattern classifier.
// Field widths, class codes, record/result layouts and controller/datapath structs.
// No dependencies.
package bipc_pkg;

  localparam int DEV_W        = 32;
  localparam int START_W      = 48;
  localparam int COUNT_W      = 20;
  localparam int TOT_W        = 64;
  localparam int NEXT_W       = 49;
  localparam int SECTOR_SHIFT = 9;
  localparam int IN_TDATA_W   = 104;
  localparam int OUT_TDATA_W  = 248;
  localparam int OUT_PAD_W    = 5;

  typedef enum logic [1:0] {
    CLS_FIRST = 2'd0,
    CLS_SEQ   = 2'd1,
    CLS_RAND  = 2'd2,
    CLS_DROP  = 2'd3
  } pclass_t;

  // per-device table record
  typedef struct packed {
    logic [NEXT_W-1:0] next_sector;
    logic [TOT_W-1:0]  bytes;
    logic [TOT_W-1:0]  rand_cnt;
    logic [TOT_W-1:0]  seq_cnt;
  } rec_t;

  // result item, lowest field in the lowest bits
  typedef struct packed {
    logic [NEXT_W-1:0] next_expected_sector;
    logic [TOT_W-1:0]  byte_total;
    logic [TOT_W-1:0]  random_total;
    logic [TOT_W-1:0]  sequential_total;
    pclass_t           pattern_class;
  } res_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic read;
    logic calc;
    logic drop;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic found;
    logic miss;
    logic full;
  } sts_t;

endpackage

>>> hdl/bipc_ctrl.sv
// Controller of the block I/O pattern classifier.
// Sequences load, table scan, record read, update and output push; uses bipc_pkg.
module bipc_ctrl
  import bipc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  output logic out_tvalid,
  input  logic out_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_CALC,
    ST_DROP,
    ST_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_tvalid_r, out_tvalid_nxt;
  logic   push;

  assign push = (state_r == ST_OUT) && (!out_tvalid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.found) state_nxt = ST_READ;
        else if (sts.miss) state_nxt = sts.full ? ST_DROP : ST_READ;
      end
      ST_READ: state_nxt = ST_CALC;
      ST_CALC: state_nxt = ST_OUT;
      ST_DROP: state_nxt = ST_OUT;
      ST_OUT: begin
        if (push) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (out_tvalid_r && out_tready) out_tvalid_nxt = 1'b0;
    if (push) out_tvalid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;

  always_comb begin
    cmd      = '0;
    cmd.load = (state_r == ST_IDLE) && in_tvalid;
    cmd.scan = (state_r == ST_SCAN);
    cmd.read = (state_r == ST_READ);
    cmd.calc = (state_r == ST_CALC);
    cmd.drop = (state_r == ST_DROP);
    cmd.push = push;
  end

endmodule

>>> hdl/bipc_dpath.sv
// Datapath of the block I/O pattern classifier.
// Device key memory with linear scan, record memory, counter update, result registers.
// Uses bipc_pkg; driven by bipc_ctrl commands.
module bipc_dpath
  import bipc_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [DEV_W-1:0]   device_id,
  input  logic [START_W-1:0] start_sector,
  input  logic [COUNT_W-1:0] sector_count,
  input  cmd_t               cmd,
  output sts_t               sts,
  output res_t               out_res
);

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_ENTRIES);

  logic [DEV_W-1:0] dev_mem [TABLE_ENTRIES];
  rec_t             rec_mem [TABLE_ENTRIES];

  logic [DEV_W-1:0]   key_r;
  logic [START_W-1:0] start_r;
  logic [COUNT_W-1:0] count_r;
  logic [CW-1:0]      fill_r;
  logic [CW-1:0]      scan_addr_r;
  logic               pend_r;
  logic [AW-1:0]      pend_idx_r;
  logic [DEV_W-1:0]   dev_q_r;
  logic [AW-1:0]      slot_r;
  logic               new_r;
  rec_t               rec_q_r;
  res_t               res_r;
  res_t               out_res_r;

  logic  issue;
  logic  found;
  logic  miss;
  rec_t  base;
  rec_t  rec_nxt;
  logic  classified;
  logic  seq_hit;
  res_t  res_nxt;

  assign issue = cmd.scan && (scan_addr_r < fill_r);
  assign found = pend_r && (dev_q_r == key_r);
  assign miss  = !pend_r && (scan_addr_r >= fill_r);

  always_comb begin
    sts       = '0;
    sts.found = found;
    sts.miss  = miss;
    sts.full  = (fill_r == FULL_CNT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      pend_r      <= 1'b0;
      scan_addr_r <= '0;
    end else begin
      if (cmd.load) begin
        key_r       <= device_id;
        start_r     <= start_sector;
        count_r     <= sector_count;
        scan_addr_r <= '0;
        pend_r      <= 1'b0;
      end else if (cmd.scan) begin
        if (issue) begin
          pend_r      <= 1'b1;
          pend_idx_r  <= scan_addr_r[AW-1:0];
          scan_addr_r <= scan_addr_r + 1'b1;
        end else begin
          pend_r <= 1'b0;
        end
        if (found) begin
          slot_r <= pend_idx_r;
          new_r  <= 1'b0;
        end else if (miss) begin
          slot_r <= fill_r[AW-1:0];
          new_r  <= 1'b1;
        end
      end
      if (cmd.calc && new_r) fill_r <= fill_r + 1'b1;
    end
  end

  // device key memory
  always_ff @(posedge clk) begin
    if (issue) dev_q_r <= dev_mem[scan_addr_r[AW-1:0]];
    if (cmd.calc && new_r) dev_mem[slot_r] <= key_r;
  end

  // record memory
  always_ff @(posedge clk) begin
    if (cmd.read) rec_q_r <= rec_mem[slot_r];
    if (cmd.calc) rec_mem[slot_r] <= rec_nxt;
  end

  always_comb begin
    base       = new_r ? '0 : rec_q_r;
    classified = (base.next_sector != '0);
    seq_hit    = (base.next_sector == {1'b0, start_r});
    rec_nxt             = base;
    rec_nxt.next_sector = {1'b0, start_r} + {{(NEXT_W-COUNT_W){1'b0}}, count_r};
    if (classified) begin
      if (seq_hit) rec_nxt.seq_cnt = base.seq_cnt + 64'd1;
      else         rec_nxt.rand_cnt = base.rand_cnt + 64'd1;
      rec_nxt.bytes = base.bytes +
        {{(TOT_W-COUNT_W-SECTOR_SHIFT){1'b0}}, count_r, {SECTOR_SHIFT{1'b0}}};
    end
  end

  always_comb begin
    res_nxt                      = '0;
    res_nxt.sequential_total     = rec_nxt.seq_cnt;
    res_nxt.random_total         = rec_nxt.rand_cnt;
    res_nxt.byte_total           = rec_nxt.bytes;
    res_nxt.next_expected_sector = rec_nxt.next_sector;
    if (!classified)  res_nxt.pattern_class = CLS_FIRST;
    else if (seq_hit) res_nxt.pattern_class = CLS_SEQ;
    else              res_nxt.pattern_class = CLS_RAND;
    // dropped item: zero totals
    if (cmd.drop) begin
      res_nxt               = '0;
      res_nxt.pattern_class = CLS_DROP;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc || cmd.drop) res_r <= res_nxt;
    if (cmd.push) out_res_r <= res_r;
  end

  assign out_res = out_res_r;

endmodule

>>> hdl/block_io_pattern_classifier.sv
// Block I/O pattern classifier: top level.
// Depends on bipc_pkg, bipc_ctrl and bipc_dpath.
//
// Usage:
//   One input item per completed block request (device, start sector, count).
//   One result item per input: class, the device's sequential, random and byte
//   totals, and the next expected sector. Devices are kept in a table of
//   TABLE_ENTRIES slots; an unknown device takes the lowest free slot, and when
//   none is free the item is dropped with class 3 and zero totals.
// Timing:
//   in_tready is high only while the block is idle. An item scans the occupied
//   slots in order in the key search (each key read is registered before the
//   compare), then takes a record read, an update and an output push, which
//   waits while the output register is held; the next item is accepted after
//   the push. The key search is the limit.
// Reset:
//   rst_n (synchronous, active low) empties the table through its fill count;
//   no clearing pass is needed and the block is ready in the next cycle.
// Stall:
//   The result sits in an output register. A new item may be accepted while it
//   waits; that item's result is held internally until the register is freed.
module block_io_pattern_classifier
  import bipc_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // device_id[31:0], start_sector[79:32], sector_count[99:80], zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // pattern_class[1:0], sequential_total[65:2], random_total[129:66],
  // byte_total[193:130], next_expected_sector[242:194], zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  cmd_t cmd;
  sts_t sts;
  res_t out_res;

  bipc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  bipc_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .device_id    (in_tdata[DEV_W-1:0]),
    .start_sector (in_tdata[DEV_W+START_W-1:DEV_W]),
    .sector_count (in_tdata[DEV_W+START_W+COUNT_W-1:DEV_W+START_W]),
    .cmd          (cmd),
    .sts          (sts),
    .out_res      (out_res)
  );

  assign out_tdata = {{OUT_PAD_W{1'b0}}, out_res};

endmodule

>>> hdl/bipc_chk.sv
// Port-level checker for the block I/O pattern classifier, bound to the top level.
// Uses bipc_pkg.
module bipc_chk
  import bipc_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] == CLS_DROP) |-> (out_tdata[OUT_TDATA_W-1:2] == '0))
    else $error("dropped item carries nonzero totals");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while one is in flight");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> in_tready && !out_tvalid)
    else $error("block not idle after reset");

endmodule

bind block_io_pattern_classifier bipc_chk u_bipc_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> tb/sv/tb_top.sv
// Testbench for block_io_pattern_classifier: directed and random block requests, with random
// gaps on the input and random stalls on the output; each result is checked against a predictor.
// Depends on bipc_pkg and the block_io_pattern_classifier RTL.
module tb_top;
  import bipc_pkg::*;

  localparam int SLOTS      = 64;
  localparam int RAND_ITEMS = 1950;
  localparam int CYCLE_CAP  = 1000000;
  localparam int DRAIN      = 100;

  localparam logic [DEV_W-1:0]   DEV_MAX   = {DEV_W{1'b1}};
  localparam logic [START_W-1:0] START_MAX = {START_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  class io_pattern_tracker;
    bit                valid[SLOTS];
    bit [DEV_W-1:0]    dev[SLOTS];
    bit [NEXT_W-1:0]   next_sector[SLOTS];
    bit [TOT_W-1:0]    seq_cnt[SLOTS];
    bit [TOT_W-1:0]    rand_cnt[SLOTS];
    bit [TOT_W-1:0]    byte_cnt[SLOTS];
    int                used;
    int                errors;
    int                result_idx;
    res_t              pending_verdicts[$];

    function void note_request(bit [DEV_W-1:0] d, bit [START_W-1:0] st,
                               bit [COUNT_W-1:0] cnt);
      int   slot;
      int   free_slot;
      res_t r;
      slot = -1;
      free_slot = -1;
      for (int i = 0; i < SLOTS; i++) begin
        if (valid[i]) begin
          if (slot < 0 && dev[i] == d) slot = i;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      if (slot < 0 && free_slot >= 0) begin
        slot = free_slot;
        valid[slot] = 1'b1;
        dev[slot] = d;
        next_sector[slot] = '0;
        seq_cnt[slot] = '0;
        rand_cnt[slot] = '0;
        byte_cnt[slot] = '0;
        used++;
      end
      r = '0;
      if (slot < 0) begin
        r.pattern_class = CLS_DROP;
        pending_verdicts.push_back(r);
        return;
      end
      r.pattern_class = CLS_FIRST;
      if (next_sector[slot] != '0) begin
        if (next_sector[slot] == NEXT_W'(st)) begin
          seq_cnt[slot] += 1;
          r.pattern_class = CLS_SEQ;
        end else begin
          rand_cnt[slot] += 1;
          r.pattern_class = CLS_RAND;
        end
        byte_cnt[slot] += TOT_W'(cnt) << SECTOR_SHIFT;
      end
      next_sector[slot] = NEXT_W'(st) + NEXT_W'(cnt);
      r.sequential_total = seq_cnt[slot];
      r.random_total = rand_cnt[slot];
      r.byte_total = byte_cnt[slot];
      r.next_expected_sector = next_sector[slot];
      pending_verdicts.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH %s", msg);
    endtask

    task compare_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want)
        report($sformatf("result %0d %s: got %h, want %h", result_idx, name, got, want));
    endtask

    task check_result(res_t got);
      res_t want;
      if (pending_verdicts.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", result_idx));
      end else begin
        want = pending_verdicts.pop_front();
        compare_field("pattern_class", 64'(got.pattern_class), 64'(want.pattern_class));
        compare_field("sequential_total", got.sequential_total, want.sequential_total);
        compare_field("random_total", got.random_total, want.random_total);
        compare_field("byte_total", got.byte_total, want.byte_total);
        compare_field("next_expected_sector", 64'(got.next_expected_sector),
                      64'(want.next_expected_sector));
      end
      result_idx++;
    endtask
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  io_pattern_tracker tracker;
  bit                calm;
  int                cycles;

  block_io_pattern_classifier #(.TABLE_ENTRIES(SLOTS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function bit idle_now();
    return !calm && ($urandom_range(0, 99) < 13);
  endfunction

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_CAP) begin
      $display("block_io_pattern_classifier regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      tracker.check_result(res_t'(out_tdata[$bits(res_t)-1:0]));
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready = rst_n && !idle_now();
    end
  end

  task send_request(bit [DEV_W-1:0] d, bit [START_W-1:0] st, bit [COUNT_W-1:0] cnt);
    @(negedge clk);
    while (idle_now()) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = IN_TDATA_W'({cnt, st, d});
    do @(posedge clk); while (!(in_tvalid && in_tready));
    tracker.note_request(d, st, cnt);
  endtask

  initial begin
    bit [DEV_W-1:0]   d;
    bit [START_W-1:0] st;
    bit [COUNT_W-1:0] cnt;
    bit [NEXT_W-1:0]  nx;
    int               pick;
    tracker = new;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // first access, zero next sector keeps it unclassified, then seq/random
    send_request('0, '0, '0);
    send_request('0, '0, '0);
    send_request('0, 48'd5, 20'd3);
    send_request('0, 48'd8, 20'd1);
    send_request('0, 48'd100, '0);
    send_request('0, 48'd100, COUNT_MAX);
    // field extremes; next sector carries into bit 48
    send_request(DEV_MAX, START_MAX, COUNT_MAX);
    send_request(DEV_MAX, START_MAX, COUNT_MAX);
    send_request(DEV_MAX, '0, '0);
    send_request(DEV_MAX, '0, '0);
    send_request(DEV_MAX, START_MAX, '0);
    send_request(DEV_MAX, START_MAX, 20'd1);
    // alternating bit patterns
    send_request(32'hAAAA_AAAA, 48'h5555_5555_5555, 20'hAAAAA);
    send_request(32'h5555_5555, 48'hAAAA_AAAA_AAAA, 20'h55555);
    send_request(32'hAAAA_AAAA, 48'h5555_555F_FFFF, 20'h55555);
    send_request(32'h5555_5555, 48'hAAAA_AAAF_FFFF, 20'hAAAAA);
    send_request(32'h5555_5555, '0, 20'd7);

    // random part: new devices fill the table, then drops mix with known traffic
    for (int n = 0; n < RAND_ITEMS; n++) begin
      calm = (n >= 900 && n < 1150);
      pick = $urandom_range(0, 99);
      st = START_W'({$urandom(), $urandom()});
      cnt = ($urandom_range(0, 9) == 0) ? COUNT_W'($urandom()) : COUNT_W'($urandom_range(1, 64));
      if (tracker.used == 0 || pick < 12) begin
        d = $urandom();
      end else begin
        d = tracker.dev[$urandom_range(0, tracker.used - 1)];
        if (pick < 16) begin
          st = '0;
          cnt = '0;
        end else if (pick < 19) begin
          st = '0;
        end else if (pick < 75) begin
          for (int i = 0; i < SLOTS; i++)
            if (tracker.valid[i] && tracker.dev[i] == d) nx = tracker.next_sector[i];
          if (nx != '0 && !nx[NEXT_W-1]) st = nx[START_W-1:0];
        end
      end
      send_request(d, st, cnt);
    end
    calm = 1'b0;
    @(negedge clk);
    in_tvalid = 1'b0;

    while (tracker.pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (tracker.errors == 0)
      $display("block_io_pattern_classifier regression: pass");
    else
      $display("block_io_pattern_classifier regression: fail");
    $finish;
  end

endmodule

>>> sim.f
hdl/bipc_pkg.sv
hdl/bipc_ctrl.sv
hdl/bipc_dpath.sv
hdl/block_io_pattern_classifier.sv
hdl/bipc_chk.sv
tb/sv/tb_top.sv
